// ===== rtl/krt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the keyed record table: sizes, action and status codes, and
// the control struct handed from the table controller to each record cell.
// Depends on nothing.
package krt_pkg;

	localparam int ENTRIES  = 64;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 64;
	localparam int ACT_W    = 3;
	localparam int STAT_W   = 3;
	localparam int COUNT_W  = 7;

	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SELECT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd4;

	// Per-cell control: take the neighbour's record, or take the broadcast record.
	typedef struct packed {
		logic shift;
		logic write;
	} krt_cell_ctl_t;

endpackage

// ===== rtl/keyed_record_table.sv =====
`timescale 1ns / 1ps
// Top level of the keyed record table: controller and the ring of record cells.
// Depends on krt_pkg and krt_cell.
//
// The table holds up to ENTRIES records, each a signed 32-bit key and a 64-bit
// payload, in a ring of cells that all move one place towards cell zero on
// every step of a search, cell zero feeding the last cell. A request with a
// known action is accepted, then searched while every record passes cell zero
// once and is compared with the key, and ended by a closing step that applies
// an insert, closes the gap left by a delete (all later cells take their
// neighbour's record at once) and loads the result register; an unknown action
// goes from acceptance straight to the closing step. No new request is taken
// until the closing step of the last one is done. The ring always makes a full
// turn so that each record comes back to its place, and that turn sets the
// length of a search. The result sits in an output register, and the closing
// step waits only while an earlier result is not yet taken. entry_count is the
// number of records held after the request; read_payload is zero except for a
// successful select. Record contents have no reset; only entries below the
// count are ever examined.
module keyed_record_table import krt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ACT_W-1:0]        action,
	input  logic signed [KEY_W-1:0] key,
	input  logic [PAY_W-1:0]        payload,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [PAY_W-1:0]        read_payload,
	output logic [COUNT_W-1:0]      entry_count
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t                  state_q;
	logic [ACT_W-1:0]        action_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0]        payload_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        pos_q;
	logic                    found_q;
	logic [PAY_W-1:0]        rd_q;
	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic [PAY_W-1:0]        rdout_q;

	logic signed [KEY_W-1:0] cell_key [ENTRIES];
	logic [PAY_W-1:0]        cell_pay [ENTRIES];
	krt_cell_ctl_t           cell_ctl [ENTRIES];

	logic                    act_known;
	logic                    scan_step;
	logic                    head_live;
	logic                    hit;
	logic                    fin_go;
	logic                    ins_wr;
	logic                    compact;
	logic [STAT_W-1:0]       fin_status;
	logic [CNT_W-1:0]        fin_count;
	logic signed [KEY_W-1:0] tail_key;
	logic [PAY_W-1:0]        tail_pay;

	assign act_known = (action == ACT_INSERT) || (action == ACT_SELECT) ||
	                   (action == ACT_UPDATE) || (action == ACT_DELETE);

	// During a search the record in cell zero is the one at index idx_q.
	assign scan_step = (state_q == S_SCAN);
	assign head_live = (CNT_W'(idx_q) < count_q);
	assign hit       = scan_step && head_live && !found_q && (cell_key[0] == key_q);

	// An update rewrites the payload as the matching record goes round the ring.
	assign tail_key = cell_key[0];
	assign tail_pay = (hit && (action_q == ACT_UPDATE)) ? payload_q : cell_pay[0];

	// The closing cycle waits until the output register is free.
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		fin_status = ST_OK;
		fin_count  = count_q;
		ins_wr     = 1'b0;
		compact    = 1'b0;
		unique case (action_q) inside
			ACT_INSERT: begin
				if (found_q) begin
					fin_status = ST_EXISTS;
				end else if (count_q == CNT_W'(ENTRIES)) begin
					fin_status = ST_FULL;
				end else begin
					ins_wr    = fin_go;
					fin_count = count_q + CNT_W'(1);
				end
			end
			ACT_SELECT, ACT_UPDATE: begin
				if (!found_q) begin
					fin_status = ST_NOT_FOUND;
				end
			end
			ACT_DELETE: begin
				if (!found_q) begin
					fin_status = ST_NOT_FOUND;
				end else begin
					compact   = fin_go;
					fin_count = count_q - CNT_W'(1);
				end
			end
			default: begin
				fin_status = ST_UNKNOWN;
			end
		endcase
	end

	// The ring of cells. Each cell takes its neighbour's record on a search step,
	// and on a delete every cell at or above the removed one does the same once.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic signed [KEY_W-1:0] nb_key;
		logic [PAY_W-1:0]        nb_pay;

		if (i == ENTRIES - 1) begin : g_tail
			assign nb_key = tail_key;
			assign nb_pay = tail_pay;
		end else begin : g_body
			assign nb_key = cell_key[i+1];
			assign nb_pay = cell_pay[i+1];
		end

		assign cell_ctl[i].shift = scan_step || (compact && (IDX_W'(i) >= pos_q));
		assign cell_ctl[i].write = ins_wr && (count_q == CNT_W'(i));

		krt_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[i]),
			.nb_key  (nb_key),
			.nb_pay  (nb_pay),
			.wr_key  (key_q),
			.wr_pay  (payload_q),
			.rec_key (cell_key[i]),
			.rec_pay (cell_pay[i])
		);
	end

	// Request controller with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			found_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one taken at the same edge.
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						action_q  <= action;
						key_q     <= key;
						payload_q <= payload;
						idx_q     <= '0;
						found_q   <= 1'b0;
						rd_q      <= '0;
						state_q   <= act_known ? S_SCAN : S_FIN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						pos_q   <= idx_q;
						if (action_q == ACT_SELECT) begin
							rd_q <= cell_pay[0];
						end
					end
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						status_q    <= fin_status;
						rdout_q     <= rd_q;
						count_q     <= fin_count;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign read_payload = rdout_q;
	assign entry_count  = COUNT_W'(count_q);

endmodule

// ===== rtl/krt_cell.sv =====
`timescale 1ns / 1ps
// One record cell of the keyed record table: a key and a payload register.
// Depends on krt_pkg.
module krt_cell import krt_pkg::*; (
	input  logic                    clk,
	input  krt_cell_ctl_t           ctl,
	input  logic signed [KEY_W-1:0] nb_key,
	input  logic [PAY_W-1:0]        nb_pay,
	input  logic signed [KEY_W-1:0] wr_key,
	input  logic [PAY_W-1:0]        wr_pay,
	output logic signed [KEY_W-1:0] rec_key,
	output logic [PAY_W-1:0]        rec_pay
);

	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0]        pay_q;

	// The write from the controller wins; shifts and writes never coincide.
	always_ff @(posedge clk) begin
		if (ctl.write) begin
			key_q <= wr_key;
			pay_q <= wr_pay;
		end else if (ctl.shift) begin
			key_q <= nb_key;
			pay_q <= nb_pay;
		end
	end

	assign rec_key = key_q;
	assign rec_pay = pay_q;

endmodule

// ===== rtl/krt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the keyed record table, bound to the top level.
// Depends on krt_pkg and keyed_record_table.
module krt_checker import krt_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [STAT_W-1:0]       status,
	input logic [PAY_W-1:0]        read_payload,
	input logic [COUNT_W-1:0]      entry_count
);

	// A held result keeps its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// A held result keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(status) && $stable(read_payload) && $stable(entry_count))
		else $error("result changed while stalled");

	// The table works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in progress");

	// Only a successful select returns a payload, and the count stays in range.
	a_result_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= COUNT_W'(ENTRIES)) &&
		((status == ST_OK) || (read_payload == '0)))
		else $error("result out of range");

endmodule

bind keyed_record_table krt_checker u_krt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.read_payload (read_payload),
	.entry_count  (entry_count)
);

// ===== test/keyed_record_table_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the keyed record table: watches both handshake channels, keeps
// a shadow copy of the table and checks every result field against it.
// Depends on krt_pkg.
module keyed_record_table_checker import krt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [ACT_W-1:0]        action,
	input  logic signed [KEY_W-1:0] key,
	input  logic [PAY_W-1:0]        payload,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [STAT_W-1:0]       status,
	input  logic [PAY_W-1:0]        read_payload,
	input  logic [COUNT_W-1:0]      entry_count,
	output int                      fail_count,
	output int                      pending,
	output int                      results_seen,
	output int                      full_rejects,
	output int                      peak_records
);

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [PAY_W-1:0]   read_payload;
		logic [COUNT_W-1:0] entry_count;
	} table_reply_t;

	logic signed [KEY_W-1:0] shadow_keys [ENTRIES];
	logic [PAY_W-1:0]        shadow_data [ENTRIES];
	int                      shadow_held;
	table_reply_t            expected_replies [$];
	table_reply_t            want;

	// Linear search over the live records only; -1 when the key is absent.
	function automatic int find_record(logic signed [KEY_W-1:0] k);
		for (int i = 0; i < shadow_held; i++)
			if (shadow_keys[i] == k)
				return i;
		return -1;
	endfunction

	function automatic table_reply_t apply_request(logic [ACT_W-1:0] act,
			logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		table_reply_t r;
		int pos;
		r.status = ST_OK;
		r.read_payload = '0;
		pos = find_record(k);
		case (act)
			ACT_INSERT: begin
				// A duplicate key is refused before the table is checked for room.
				if (pos >= 0)
					r.status = ST_EXISTS;
				else if (shadow_held >= ENTRIES)
					r.status = ST_FULL;
				else begin
					shadow_keys[shadow_held] = k;
					shadow_data[shadow_held] = p;
					shadow_held++;
				end
			end
			ACT_SELECT: begin
				if (pos < 0)
					r.status = ST_NOT_FOUND;
				else
					r.read_payload = shadow_data[pos];
			end
			ACT_UPDATE: begin
				if (pos < 0)
					r.status = ST_NOT_FOUND;
				else
					shadow_data[pos] = p;
			end
			ACT_DELETE: begin
				if (pos < 0)
					r.status = ST_NOT_FOUND;
				else begin
					for (int i = pos; i < shadow_held - 1; i++) begin
						shadow_keys[i] = shadow_keys[i + 1];
						shadow_data[i] = shadow_data[i + 1];
					end
					shadow_held--;
				end
			end
			default: r.status = ST_UNKNOWN;
		endcase
		r.entry_count = COUNT_W'(shadow_held);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// A result leaving at an edge always belongs to an earlier request, so the
	// comparison is made before the request taken at the same edge is applied.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_held = 0;
			expected_replies.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			full_rejects = 0;
			peak_records = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_replies.size() == 0)
					report_mismatch($sformatf("result with nothing outstanding: status %0d",
						status));
				else begin
					want = expected_replies.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status got %0d, expected %0d",
							status, want.status));
					if (read_payload !== want.read_payload)
						report_mismatch($sformatf("read_payload got %h, expected %h",
							read_payload, want.read_payload));
					if (entry_count !== want.entry_count)
						report_mismatch($sformatf("entry_count got %0d, expected %0d",
							entry_count, want.entry_count));
				end
			end
			if (in_valid && in_ready) begin
				want = apply_request(action, key, payload);
				expected_replies.push_back(want);
				if (want.status == ST_FULL)
					full_rejects++;
				if (shadow_held > peak_records)
					peak_records = shadow_held;
			end
			pending = expected_replies.size();
		end
	end

endmodule

// ===== test/keyed_record_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the keyed record table: clock, reset, request stimulus and
// result back-pressure, with the verdict taken from keyed_record_table_checker.
// Depends on krt_pkg, keyed_record_table and keyed_record_table_checker.
module keyed_record_table_tb;
	import krt_pkg::*;

	// Roughly 2000 random requests follow the directed opening. The slowest
	// legal transaction costs a full turn of the ring plus a sender gap and a
	// receiver stall, so the cycle limit leaves a margin of several times over.
	localparam int RANDOM_ITEMS = 2000;
	localparam int BLOCK_ITEMS  = 100;
	localparam int POOL_SIZE    = 80;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int SETTLE       = ENTRIES + 8;

	// The package names only the four real actions; everything from here up
	// is an unknown action.
	localparam logic [ACT_W-1:0] ACT_FIRST_UNKNOWN = 3'd4;
	localparam logic [ACT_W-1:0] ACT_LAST_UNKNOWN  = 3'd7;

	// Each random block leans one way, so the table is driven up to full,
	// drained back towards empty, or left to wander in the middle.
	typedef enum int {FILL_UP, DRAIN_DOWN, EVEN_MIX} load_mix_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [ACT_W-1:0]        action = '0;
	logic signed [KEY_W-1:0] key = '0;
	logic [PAY_W-1:0]        payload = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STAT_W-1:0]       status;
	logic [PAY_W-1:0]        read_payload;
	logic [COUNT_W-1:0]      entry_count;

	int fail_count;
	int pending;
	int results_seen;
	int full_rejects;
	int peak_records;
	int cycle_count = 0;
	int requests_sent = 0;

	// When set, the sender leaves no gaps between transactions.
	logic sender_calm = 1'b0;
	logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

	always #4 clk = ~clk;

	keyed_record_table DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.key          (key),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.read_payload (read_payload),
		.entry_count  (entry_count)
	);

	keyed_record_table_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.key          (key),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.read_payload (read_payload),
		.entry_count  (entry_count),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.full_rejects (full_rejects),
		.peak_records (peak_records)
	);

	// Presents one request and returns at the edge where it is taken. Valid is
	// only dropped when a gap is wanted, so back-to-back transactions keep it
	// high without a second assignment in the same time step.
	task automatic send_request(logic [ACT_W-1:0] act, logic signed [KEY_W-1:0] k,
			logic [PAY_W-1:0] p);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		key <= k;
		payload <= p;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	function automatic logic [PAY_W-1:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	// Picks one of the four real actions with weights that follow the block's
	// leaning; unknown codes are mixed in separately by the caller.
	function automatic logic [ACT_W-1:0] choose_action(load_mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		case (mix)
			FILL_UP: begin
				if (roll < 65) return ACT_INSERT;
				if (roll < 80) return ACT_SELECT;
				if (roll < 90) return ACT_UPDATE;
				return ACT_DELETE;
			end
			DRAIN_DOWN: begin
				if (roll < 15) return ACT_INSERT;
				if (roll < 30) return ACT_SELECT;
				if (roll < 40) return ACT_UPDATE;
				return ACT_DELETE;
			end
			default: begin
				if (roll < 30) return ACT_INSERT;
				if (roll < 60) return ACT_SELECT;
				if (roll < 80) return ACT_UPDATE;
				return ACT_DELETE;
			end
		endcase
	endfunction

	// The receiver draws a stall before each result and, now and then, goes
	// through a stretch of forty results taken without any stall at all.
	initial begin
		int stall;
		int taken;
		logic calm;
		taken = 0;
		calm = 1'b0;
		forever begin
			if (taken % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			stall = calm ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// A watchdog: a run that hangs or loses a result ends here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				CYCLE_LIMIT, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		load_mix_t mix;
		logic [ACT_W-1:0] act;
		logic signed [KEY_W-1:0] k;

		// The pool always holds the key extremes, so they keep turning up in
		// the random part; it is larger than the table so that a full table
		// still sees new keys and lookups of absent keys stay common.
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7FFF_FFFF;
		key_pool[2] = '0;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. An empty table first: every lookup misses.
		send_request(ACT_SELECT, '0, random_word());
		send_request(ACT_DELETE, 32'sd5, random_word());
		send_request(ACT_UPDATE, 32'sd5, random_word());
		// The key extremes, zero and minus one, with payload extremes.
		send_request(ACT_INSERT, 32'sh8000_0000, '1);
		send_request(ACT_INSERT, 32'sh7FFF_FFFF, '0);
		send_request(ACT_INSERT, '0, 64'h5555_5555_5555_5555);
		send_request(ACT_INSERT, -32'sd1, 64'hAAAA_AAAA_AAAA_AAAA);
		// A duplicate insert leaves the table alone.
		send_request(ACT_INSERT, 32'sh7FFF_FFFF, '1);
		send_request(ACT_SELECT, 32'sh8000_0000, random_word());
		send_request(ACT_SELECT, 32'sh7FFF_FFFF, random_word());
		send_request(ACT_UPDATE, '0, 64'h0123_4567_89AB_CDEF);
		send_request(ACT_SELECT, '0, random_word());
		// Deleting from the middle moves the later records down one place;
		// the following selects show the moved record kept its payload.
		send_request(ACT_DELETE, 32'sh7FFF_FFFF, random_word());
		send_request(ACT_SELECT, -32'sd1, random_word());
		send_request(ACT_SELECT, 32'sh7FFF_FFFF, random_word());
		// Deleting the first and then the last record.
		send_request(ACT_DELETE, 32'sh8000_0000, random_word());
		send_request(ACT_DELETE, -32'sd1, random_word());
		send_request(ACT_SELECT, '0, random_word());
		// Every unknown action code, each of which must change nothing.
		for (int c = ACT_FIRST_UNKNOWN; c <= ACT_LAST_UNKNOWN; c++)
			send_request(ACT_W'(c), '0, random_word());
		send_request(ACT_DELETE, '0, random_word());
		send_request(ACT_SELECT, '0, random_word());

		// Random part, in blocks that each pick a leaning and whether the
		// sender runs flat out. Filling blocks drive the table to full, where
		// inserts of new keys are refused and duplicates still come back as
		// key exists.
		for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
			mix = load_mix_t'($urandom_range(0, 2));
			sender_calm = ($urandom_range(0, 4) == 0);
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 5)
					act = ACT_W'($urandom_range(ACT_FIRST_UNKNOWN, ACT_LAST_UNKNOWN));
				else
					act = choose_action(mix);
				if ($urandom_range(0, 9) == 0)
					k = $urandom();
				else
					k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				send_request(act, k, random_word());
			end
		end
		in_valid <= 1'b0;

		// Sampling on the falling edge keeps this wait clear of the edge at
		// which the checker updates its count of outstanding results.
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d requests sent and %0d results checked over %0d cycles",
			requests_sent, results_seen, cycle_count);
		$display("table peaked at %0d of %0d records; %0d inserts refused as table full",
			peak_records, ENTRIES, full_rejects);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/krt_pkg.sv
rtl/krt_cell.sv
rtl/keyed_record_table.sv
rtl/krt_checker.sv
test/keyed_record_table_checker.sv
test/keyed_record_table_tb.sv
